// ===== rtl/core/pvfs_pkg.sv =====
package pvfs_pkg;

  // message fields and registers
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned FieldW   = 29;
  localparam int unsigned CountW   = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned WireW    = 3;

  // index of the fifth and last byte of a varint, which starts at bit 28
  localparam logic [CountW-1:0] VarintLastIdx = CountW'(4);

  // field number sought after reset
  localparam logic [FieldW-1:0] TargetReset = FieldW'(7);

  // reported status codes
  localparam logic [StatusW-1:0] StFound  = 2'd0;
  localparam logic [StatusW-1:0] StAbsent = 2'd1;
  localparam logic [StatusW-1:0] StBad    = 2'd2;

  // wire types
  localparam logic [WireW-1:0] WtVarint  = 3'd0;
  localparam logic [WireW-1:0] WtFixed64 = 3'd1;
  localparam logic [WireW-1:0] WtLenDel  = 3'd2;
  localparam logic [WireW-1:0] WtFixed32 = 3'd5;

  // payload lengths of the fixed wire types
  localparam logic [ValueW-1:0] Fixed64Len = ValueW'(8);
  localparam logic [ValueW-1:0] Fixed32Len = ValueW'(4);

  // one byte folded into the varint being decoded
  typedef struct packed {
    logic              done;   // continuation bit clear, varint complete
    logic              bad;    // continuation bit set on the fifth byte
    logic [CountW-1:0] count;  // bytes taken including this one
    logic [ValueW-1:0] value;  // accumulated value including this byte
  } varint_res_t;

endpackage

// ===== rtl/core/pvfs_varint.sv =====
module pvfs_varint import pvfs_pkg::*; (
  input  logic [ValueW-1:0] acc_i,
  input  logic [CountW-1:0] count_i,
  input  logic [ByteW-1:0]  data_i,
  output varint_res_t       res_o
);

  logic [4:0]        shamt;
  logic [ValueW-1:0] payload;

  // seven payload bits per byte, bits past 32 fall off
  always_comb begin
    unique case (count_i)
      3'd0:    shamt = 5'd0;
      3'd1:    shamt = 5'd7;
      3'd2:    shamt = 5'd14;
      3'd3:    shamt = 5'd21;
      3'd4:    shamt = 5'd28;
      default: shamt = 5'd0;
    endcase
  end

  assign payload = {{(ValueW-7){1'b0}}, data_i[6:0]} << shamt;

  // merge and classify
  assign res_o.value = acc_i | payload;
  assign res_o.count = count_i + CountW'(1);
  assign res_o.done  = ~data_i[7];
  assign res_o.bad   = data_i[7] && (count_i == VarintLastIdx);

endmodule

// ===== rtl/core/protobuf_varint_field_scanner_core.sv =====
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    data_byte_i[7:0], last_byte_i
// out      out  out_valid_o / out_ready_i  status_o[1:0], found_value_o[31:0]
// cfg      in   cfg_valid_i / cfg_ready_o  target_field_i[28:0]
//
// one byte is taken per cycle while in_ready_o is high; parser state updates
// in the accepting cycle; a result is valid in the cycle after its last byte
// a non-last byte is taken even while a result waits; a last byte needs the
// result register free or emptied in the same cycle
// reset clears the parser, empties the result register, target becomes 7
module protobuf_varint_field_scanner_core import pvfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [ValueW-1:0]   found_value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [FieldW-1:0]   target_field_i
);

  typedef enum logic [2:0] {
    PhTag,
    PhValue,
    PhSkipVar,
    PhLen,
    PhSkipBytes
  } phase_e;

  typedef enum logic [1:0] {
    OcUndecided,
    OcFound,
    OcBad
  } outcome_e;

  phase_e              phase_q, phase_d;
  outcome_e            outcome_q, outcome_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0]   skip_q, skip_d;
  logic [ValueW-1:0]   held_q, held_d;
  logic [FieldW-1:0]   target_q;
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ValueW-1:0]   value_q, value_d;

  logic                in_fire;
  logic                cfg_fire;
  varint_res_t         vres;
  logic [ValueW-1:0]   skip_dec;
  logic [WireW-1:0]    wire_type;
  logic [FieldW-1:0]   field_num;

  // handshakes
  assign in_ready_o  = ~out_valid_q | out_ready_i | ~last_byte_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // varint byte merge
  pvfs_varint u_varint (
    .acc_i   (acc_q),
    .count_i (cnt_q),
    .data_i  (data_byte_i),
    .res_o   (vres)
  );

  assign wire_type = vres.value[WireW-1:0];
  assign field_num = vres.value[ValueW-1:WireW];
  assign skip_dec  = (skip_q == '0) ? '0 : skip_q - ValueW'(1);

  // parser next state
  always_comb begin
    phase_d   = phase_q;
    outcome_d = outcome_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    held_d    = held_q;
    if (in_fire && (outcome_q == OcUndecided)) begin
      if (phase_q == PhSkipBytes) begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PhTag;
        end
      end else if (vres.bad) begin
        outcome_d = OcBad;
      end else if (!vres.done) begin
        acc_d = vres.value;
        cnt_d = vres.count;
      end else begin
        acc_d = '0;
        cnt_d = '0;
        unique case (phase_q)
          PhTag: begin
            priority if (field_num == target_q && wire_type == WtVarint) begin
              phase_d = PhValue;
            end else if (wire_type == WtVarint) begin
              phase_d = PhSkipVar;
            end else if (wire_type == WtFixed64) begin
              skip_d  = Fixed64Len;
              phase_d = PhSkipBytes;
            end else if (wire_type == WtLenDel) begin
              phase_d = PhLen;
            end else if (wire_type == WtFixed32) begin
              skip_d  = Fixed32Len;
              phase_d = PhSkipBytes;
            end else begin
              outcome_d = OcBad;
            end
          end
          PhValue: begin
            held_d    = vres.value;
            outcome_d = OcFound;
          end
          PhLen: begin
            skip_d  = vres.value;
            phase_d = (vres.value == '0) ? PhTag : PhSkipBytes;
          end
          default: begin
            phase_d = PhTag;
          end
        endcase
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    status_d    = status_q;
    value_d     = value_q;
    if (in_fire && last_byte_i) begin
      out_valid_d = 1'b1;
      value_d     = '0;
      priority if (outcome_d == OcFound) begin
        status_d = StFound;
        value_d  = held_d;
      end else if (outcome_d == OcBad) begin
        status_d = StBad;
      end else if (phase_d == PhTag && cnt_d == '0) begin
        status_d = StAbsent;
      end else begin
        status_d = StBad;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhTag;
      outcome_q   <= OcUndecided;
      acc_q       <= '0;
      cnt_q       <= '0;
      skip_q      <= '0;
      target_q    <= TargetReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        target_q <= target_field_i;
      end
      out_valid_q <= out_valid_d;
      if (in_fire && last_byte_i) begin
        phase_q   <= PhTag;
        outcome_q <= OcUndecided;
        acc_q     <= '0;
        cnt_q     <= '0;
        skip_q    <= '0;
      end else begin
        phase_q   <= phase_d;
        outcome_q <= outcome_d;
        acc_q     <= acc_d;
        cnt_q     <= cnt_d;
        skip_q    <= skip_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    held_q   <= held_d;
    status_q <= status_d;
    value_q  <= value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = value_q;

  // checks
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> out_valid_o)
    else $error("last byte accepted without a result");

  a_last_clears_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=>
      (phase_q == PhTag && outcome_q == OcUndecided && cnt_q == '0 && acc_q == '0))
    else $error("parser not cleared after a message");

  a_varint_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= VarintLastIdx)
    else $error("varint byte count past the limit");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkipBytes) |-> (skip_q != '0))
    else $error("skipping with nothing left to skip");

  a_value_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StFound) |-> (found_value_o == '0))
    else $error("value reported without a found status");

endmodule
